>>> rtl/core/spq_pkg.sv
package spq_pkg;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int PAYLOAD_BITS = 9;
    localparam int OUT_WEIGHT_BITS = 16;
    localparam int OUT_COUNT_BITS = 9;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cmd;

endpackage

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue, least weight first, built as a chain of cells.
// Request channel: i_req_type, i_weight, i_payload are taken at a rising edge
// with i_start high and o_busy low. i_req_type selects insert or pop.
// Every request beat yields one result beat in the next cycle: o_done is high
// for exactly one cycle with o_status, o_popped_weight, o_popped_payload and
// o_entry_count. The receiver cannot stall; results are not held.
// Throughput is one request per cycle: every cell compares its weight with the
// new one in parallel and shifts toward its neighbor in the same cycle, so
// o_busy stays low. The result outputs are driven from the result register.
// Equal weights leave in arrival order. A pop from an empty queue returns
// status empty; an insert into a full queue is dropped with status full.
// Reset (synchronous, active low) empties the queue and clears o_done.
module sorted_priority_queue #(
    parameter int CAPACITY    = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_req_type,
    input  logic [spq_pkg::OUT_WEIGHT_BITS-1:0]  i_weight,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0]     i_payload,
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic [spq_pkg::OUT_WEIGHT_BITS-1:0]  o_popped_weight,
    output logic [spq_pkg::PAYLOAD_BITS-1:0]     o_popped_payload,
    output logic [spq_pkg::OUT_COUNT_BITS-1:0]   o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                             accept;
    logic                             is_full;
    logic                             is_empty;
    spq_pkg::t_cmd                    cmd;
    logic [WEIGHT_BITS-1:0]           new_weight;

    logic                             cell_gt      [CAPACITY];
    logic                             cell_valid   [CAPACITY];
    logic [WEIGHT_BITS-1:0]           cell_weight  [CAPACITY];
    logic [spq_pkg::PAYLOAD_BITS-1:0] cell_payload [CAPACITY];

    logic [CW-1:0]                       r_count, n_count;
    logic                                r_done;
    logic [1:0]                          r_status, n_status;
    logic [spq_pkg::OUT_WEIGHT_BITS-1:0] r_pw, n_pw;
    logic [spq_pkg::PAYLOAD_BITS-1:0]    r_pp, n_pp;

    assign o_busy     = 1'b0;
    assign accept     = i_start && !o_busy;
    assign is_full    = (r_count == CW'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign new_weight = WEIGHT_BITS'(i_weight);

    assign cmd.ins = accept && (i_req_type == spq_pkg::REQ_INSERT) && !is_full;
    assign cmd.pop = accept && (i_req_type == spq_pkg::REQ_POP) && !is_empty;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                             left_gt;
        logic                             left_valid;
        logic [WEIGHT_BITS-1:0]           left_weight;
        logic [spq_pkg::PAYLOAD_BITS-1:0] left_payload;
        logic                             right_valid;
        logic [WEIGHT_BITS-1:0]           right_weight;
        logic [spq_pkg::PAYLOAD_BITS-1:0] right_payload;

        if (i == 0) begin : g_head
            assign left_gt      = 1'b0;
            assign left_valid   = 1'b1;
            assign left_weight  = new_weight;
            assign left_payload = i_payload;
        end else begin : g_mid
            assign left_gt      = cell_gt[i-1];
            assign left_valid   = cell_valid[i-1];
            assign left_weight  = cell_weight[i-1];
            assign left_payload = cell_payload[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_valid   = 1'b0;
            assign right_weight  = '0;
            assign right_payload = '0;
        end else begin : g_body
            assign right_valid   = cell_valid[i+1];
            assign right_weight  = cell_weight[i+1];
            assign right_payload = cell_payload[i+1];
        end

        spq_cell #(
            .WEIGHT_BITS(WEIGHT_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (cmd),
            .i_new_weight    (new_weight),
            .i_new_payload   (i_payload),
            .i_left_gt       (left_gt),
            .i_left_valid    (left_valid),
            .i_left_weight   (left_weight),
            .i_left_payload  (left_payload),
            .i_right_valid   (right_valid),
            .i_right_weight  (right_weight),
            .i_right_payload (right_payload),
            .o_gt            (cell_gt[i]),
            .o_valid         (cell_valid[i]),
            .o_weight        (cell_weight[i]),
            .o_payload       (cell_payload[i])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        n_pw     = '0;
        n_pp     = '0;
        if (i_req_type == spq_pkg::REQ_INSERT) begin
            if (is_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                // head cell holds the least weight
                n_pw    = spq_pkg::OUT_WEIGHT_BITS'(cell_weight[0]);
                n_pp    = cell_payload[0];
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_pw     <= n_pw;
            r_pp     <= n_pp;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_popped_weight  = r_pw;
    assign o_popped_payload = r_pp;
    assign o_entry_count    = spq_pkg::OUT_COUNT_BITS'(r_count);

endmodule

>>> rtl/core/spq_cell.sv
module spq_cell #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_cmd                     i_cmd,
    input  logic [WEIGHT_BITS-1:0]            i_new_weight,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0]  i_new_payload,
    input  logic                              i_left_gt,
    input  logic                              i_left_valid,
    input  logic [WEIGHT_BITS-1:0]            i_left_weight,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0]  i_left_payload,
    input  logic                              i_right_valid,
    input  logic [WEIGHT_BITS-1:0]            i_right_weight,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0]  i_right_payload,
    output logic                              o_gt,
    output logic                              o_valid,
    output logic [WEIGHT_BITS-1:0]            o_weight,
    output logic [spq_pkg::PAYLOAD_BITS-1:0]  o_payload
);

    logic                             r_valid;
    logic [WEIGHT_BITS-1:0]           r_weight;
    logic [spq_pkg::PAYLOAD_BITS-1:0] r_payload;

    // an empty cell counts as heavier, so the new entry lands at the tail
    assign o_gt = !r_valid || (r_weight > i_new_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_valid <= i_right_valid;
        end else if (i_cmd.ins && o_gt) begin
            r_valid <= i_left_gt ? i_left_valid : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_weight  <= i_right_weight;
            r_payload <= i_right_payload;
        end else if (i_cmd.ins && o_gt) begin
            // shift right behind the insertion point, take the new entry at it
            if (i_left_gt) begin
                r_weight  <= i_left_weight;
                r_payload <= i_left_payload;
            end else begin
                r_weight  <= i_new_weight;
                r_payload <= i_new_payload;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_weight  = r_weight;
    assign o_payload = r_payload;

endmodule

>>> tb/sv/tb.sv
module tb;

    localparam int CAPACITY    = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int NUM_REQS    = 1750;
    localparam int MAX_GAP     = 19;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 8;

    // weight flavors for random phases
    localparam int WMODE_FULL    = 0;
    localparam int WMODE_NARROW  = 1;
    localparam int WMODE_EXTREME = 2;

    // gap flavors for random phases
    localparam int GMODE_NONE   = 0;
    localparam int GMODE_RANDOM = 1;
    localparam int GMODE_SPARSE = 2;

    typedef struct {
        logic                                req;
        logic [spq_pkg::OUT_WEIGHT_BITS-1:0] weight;
        logic [spq_pkg::PAYLOAD_BITS-1:0]    payload;
        int unsigned                         gap;
    } t_req;

    typedef struct {
        logic [1:0]                          status;
        logic [spq_pkg::OUT_WEIGHT_BITS-1:0] weight;
        logic [spq_pkg::PAYLOAD_BITS-1:0]    payload;
        logic [spq_pkg::OUT_COUNT_BITS-1:0]  count;
    } t_result;

    typedef struct {
        logic [spq_pkg::OUT_WEIGHT_BITS-1:0] weight;
        logic [spq_pkg::PAYLOAD_BITS-1:0]    payload;
    } t_entry;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_start = 1'b0;
    logic                                i_req_type = spq_pkg::REQ_INSERT;
    logic [spq_pkg::OUT_WEIGHT_BITS-1:0] i_weight = '0;
    logic [spq_pkg::PAYLOAD_BITS-1:0]    i_payload = '0;
    logic                                o_busy;
    logic                                o_done;
    logic [1:0]                          o_status;
    logic [spq_pkg::OUT_WEIGHT_BITS-1:0] o_popped_weight;
    logic [spq_pkg::PAYLOAD_BITS-1:0]    o_popped_payload;
    logic [spq_pkg::OUT_COUNT_BITS-1:0]  o_entry_count;

    t_req        queued_reqs[$];
    t_result     due_results[$];
    t_entry      held_entries[$];
    int          gen_count = 0;
    int unsigned gap_left = 0;
    int          quiet_cycles = 0;
    bit          failed = 1'b0;

    sorted_priority_queue #(
        .CAPACITY   (CAPACITY),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_weight        (i_weight),
        .i_payload       (i_payload),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_popped_weight (o_popped_weight),
        .o_popped_payload(o_popped_payload),
        .o_entry_count   (o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sorted insert behind equal weights, pop from the front
    function automatic t_result queue_step(t_req r);
        t_result res;
        t_entry  e;
        int      pos;
        res.status  = spq_pkg::ST_OK;
        res.weight  = '0;
        res.payload = '0;
        if (r.req == spq_pkg::REQ_INSERT) begin
            if (held_entries.size() >= CAPACITY) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].weight <= r.weight)
                    pos++;
                e.weight  = r.weight;
                e.payload = r.payload;
                held_entries.insert(pos, e);
            end
        end else if (held_entries.size() == 0) begin
            res.status = spq_pkg::ST_EMPTY;
        end else begin
            e = held_entries.pop_front();
            res.weight  = e.weight;
            res.payload = e.payload;
        end
        res.count = spq_pkg::OUT_COUNT_BITS'(held_entries.size());
        return res;
    endfunction

    task automatic add_req(logic req, int unsigned weight, int unsigned payload,
                           int unsigned gap);
        t_req r;
        r.req     = req;
        r.weight  = spq_pkg::OUT_WEIGHT_BITS'(weight);
        r.payload = spq_pkg::PAYLOAD_BITS'(payload);
        r.gap     = gap;
        queued_reqs.push_back(r);
        if (req == spq_pkg::REQ_INSERT) begin
            if (gen_count < CAPACITY) gen_count++;
        end else if (gen_count > 0) begin
            gen_count--;
        end
    endtask

    function automatic int unsigned draw_weight(int mode);
        case (mode)
            WMODE_NARROW:  return $urandom_range(0, 7);
            WMODE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return 0;
                    1:       return 1;
                    2:       return 65534;
                    default: return 65535;
                endcase
            end
            default:       return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int unsigned draw_gap(int mode);
        case (mode)
            GMODE_RANDOM: return $urandom_range(0, MAX_GAP);
            GMODE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
            default:      return 0;
        endcase
    endfunction

    task automatic add_random(logic req, int wmode, int gmode);
        add_req(req, draw_weight(wmode), $urandom_range(0, 511), draw_gap(gmode));
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    // driver: present the head request, hold start until the beat is taken
    always @(posedge i_clk) begin
        logic next_start;
        t_req head;
        next_start = i_start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                head = queued_reqs.pop_front();
                due_results.push_back(queue_step(head));
                next_start = 1'b0;
                if (queued_reqs.size() != 0) gap_left = queued_reqs[0].gap;
            end
            if (!next_start && queued_reqs.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    head = queued_reqs[0];
                    i_req_type <= head.req;
                    i_weight   <= head.weight;
                    i_payload  <= head.payload;
                    next_start = 1'b1;
                end
            end
        end
        i_start <= next_start;
    end

    // monitor: every done beat is matched against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                $error("result beat with no request outstanding");
                failed = 1'b1;
            end else begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("popped_weight", 32'(want.weight), 32'(o_popped_weight));
                check_field("popped_payload", 32'(want.payload), 32'(o_popped_payload));
                check_field("entry_count", 32'(want.count), 32'(o_entry_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int wmode;
        int gmode;
        int n;
        int phase;

        // empty pop, equal weights in arrival order, both weight extremes
        add_req(spq_pkg::REQ_POP, 65535, 511, 0);
        add_req(spq_pkg::REQ_INSERT, 100, 1, 0);
        add_req(spq_pkg::REQ_INSERT, 100, 2, 0);
        add_req(spq_pkg::REQ_INSERT, 0, 0, 3);
        add_req(spq_pkg::REQ_INSERT, 65535, 511, 0);
        add_req(spq_pkg::REQ_INSERT, 100, 3, 1);
        add_req(spq_pkg::REQ_INSERT, 50, 4, 0);
        add_req(spq_pkg::REQ_INSERT, 65535, 0, 0);
        repeat (7) add_req(spq_pkg::REQ_POP, 0, 0, 0);
        add_req(spq_pkg::REQ_POP, 65535, 511, 2);
        add_req(spq_pkg::REQ_POP, 0, 0, 0);
        add_req(spq_pkg::REQ_INSERT, 0, 511, 0);
        add_req(spq_pkg::REQ_INSERT, 65535, 0, 5);
        add_req(spq_pkg::REQ_POP, 21845, 170, 0);
        add_req(spq_pkg::REQ_POP, 43690, 341, 0);
        add_req(spq_pkg::REQ_POP, 0, 0, 0);

        // fill to capacity first, then drain, then random phases
        phase = 0;
        while (queued_reqs.size() < NUM_REQS) begin
            wmode = $urandom_range(WMODE_FULL, WMODE_EXTREME);
            gmode = $urandom_range(GMODE_NONE, GMODE_SPARSE);
            case (phase == 0 ? 0 : phase == 1 ? 1 : $urandom_range(0, 2))
                0: begin
                    while (gen_count < CAPACITY)
                        add_random(($urandom_range(0, 9) == 0) ? spq_pkg::REQ_POP
                                                               : spq_pkg::REQ_INSERT,
                                   wmode, gmode);
                    repeat ($urandom_range(3, 10))
                        add_random(spq_pkg::REQ_INSERT, wmode, gmode);
                end
                1: begin
                    while (gen_count > 0)
                        add_random(($urandom_range(0, 9) == 0) ? spq_pkg::REQ_INSERT
                                                               : spq_pkg::REQ_POP,
                                   wmode, gmode);
                    repeat ($urandom_range(2, 6)) add_random(spq_pkg::REQ_POP, wmode, gmode);
                end
                default: begin
                    n = $urandom_range(20, 120);
                    repeat (n) add_random($urandom_range(0, 1) ? spq_pkg::REQ_POP
                                                               : spq_pkg::REQ_INSERT,
                                          wmode, gmode);
                end
            endcase
            phase++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_reqs.size() != 0 || due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (failed) begin
            $display("CHECK FAILED");
        end else begin
            $display("CHECK OK");
        end
        $finish;
    end

endmodule

>>> sorted_priority_queue.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/sv/tb.sv
